// File: src/sps_pkg.sv
// Shared constants, codes and controller/datapath types for the sieve unit.
package sps_pkg;

    localparam int MAX_LIMIT   = 65535;
    localparam int PRIME_DEPTH = 8192;
    localparam int MIN_LIMIT   = 2;

    localparam int FIELD_W  = 16;                        // value fields on the ports
    localparam int ADDR_W   = $clog2(MAX_LIMIT + 1);     // table index / stored factor
    localparam int WIDE_W   = (ADDR_W > FIELD_W) ? ADDR_W : FIELD_W;
    localparam int PROD_W   = 2 * ADDR_W;
    localparam int PIDX_W   = $clog2(PRIME_DEPTH);
    localparam int STORED_W = PIDX_W + 1;
    localparam int COUNT_W  = 14;
    localparam int COUNT_MAX = 16383;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_RANGE   = 2'd1,
        STATUS_UNBUILT = 2'd2
    } status_t;

    typedef enum logic {
        OP_BUILD = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_Q_RES,
        ST_CLR,
        ST_RD_I,
        ST_CHK_I,
        ST_RD_P,
        ST_MUL,
        ST_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic q_read;
        logic build_start;
        logic clr_step;
        logic rd_i;
        logic chk_i;
        logic rd_p;
        logic mul;
        logic wr_prod;
        logic next_i;
        logic k_next;
        logic load_q;
        logic load_b;
    } sps_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic prod_over;
        logic inner_last;
        logic i_last;
        logic out_free;
    } sps_stat_t;

endpackage

// File: src/sps_if.sv
// Handshake channel interfaces: request, response and configuration write.
interface sps_req_if import sps_pkg::*;;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [FIELD_W-1:0] query_value;

    modport source (output valid, output opcode, output query_value, input ready);
    modport sink   (input valid, input opcode, input query_value, output ready);
endinterface

interface sps_rsp_if import sps_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [FIELD_W-1:0] smallest_factor;
    logic               is_prime;
    logic [COUNT_W-1:0] prime_count;

    modport source (output valid, output status, output smallest_factor,
                    output is_prime, output prime_count, input ready);
    modport sink   (input valid, input status, input smallest_factor,
                    input is_prime, input prime_count, output ready);
endinterface

interface sps_cfg_if import sps_pkg::*;;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] sieve_limit;

    modport source (output valid, output sieve_limit, input ready);
    modport sink   (input valid, input sieve_limit, output ready);
endinterface

// File: src/smallest_prime_factor_sieve_unit.sv
// Top level of the linear sieve unit: sequencer plus datapath.
// Query: the accept edge issues the table read; the result is loaded once the output reg is free.
// Build: a clear pass over entries 0..limit, then per i a table read and check, plus per list prime
//   tried a list read, a multiply and a write.
// One item in flight; a new item is taken while the previous result waits in the output reg.
// Reset (async, active low): table unbuilt, count 0, limit 65535; memory contents undefined.
module smallest_prime_factor_sieve_unit import sps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    sps_cfg_if.sink  cfg,
    sps_req_if.sink  req,
    sps_rsp_if.source rsp
);

    sps_cmd_t  cmd;
    sps_stat_t stat;
    logic      req_ready;

    // Config writes are always taken; the host must write only while idle, which the block does not enforce.
    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

    // Sequencer: decodes items and steps the clear pass and sieve walk.
    sps_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_opcode (req.opcode),
        .req_ready  (req_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Datapath: factor table, prime list, 16x16 multiplier, result register.
    sps_dp u_dp
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .cfg_we              (cfg.valid),
        .cfg_limit           (cfg.sieve_limit),
        .req_query_value     (req.query_value),
        .rsp_ready           (rsp.ready),
        .rsp_valid           (rsp.valid),
        .rsp_status          (rsp.status),
        .rsp_smallest_factor (rsp.smallest_factor),
        .rsp_is_prime        (rsp.is_prime),
        .rsp_prime_count     (rsp.prime_count)
    );

endmodule

// File: src/sps_ctrl.sv
// Sequencer: query handling, table clear and linear sieve walk.
module sps_ctrl import sps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_opcode,
    output logic      req_ready,
    input  sps_stat_t stat,
    output sps_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req_opcode == OP_QUERY) ? ST_Q_RES : ST_CLR;
                end
            end
            ST_Q_RES:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                if (stat.clr_last)
                begin
                    state_next = ST_RD_I;
                end
            end
            ST_RD_I:  state_next = ST_CHK_I;
            ST_CHK_I: state_next = ST_RD_P;   // list is never empty here
            ST_RD_P:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_WR;
            ST_WR:
            begin
                if (stat.prod_over || stat.inner_last)
                begin
                    state_next = stat.i_last ? ST_DONE : ST_RD_I;
                end
                else
                begin
                    state_next = ST_RD_P;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.q_read      = (req_opcode == OP_QUERY);
                    cmd.build_start = (req_opcode != OP_QUERY);
                end
            end
            ST_Q_RES: cmd.load_q   = stat.out_free;
            ST_CLR:   cmd.clr_step = 1'b1;
            ST_RD_I:  cmd.rd_i     = 1'b1;
            ST_CHK_I: cmd.chk_i    = 1'b1;
            ST_RD_P:  cmd.rd_p     = 1'b1;
            ST_MUL:   cmd.mul      = 1'b1;
            ST_WR:
            begin
                cmd.wr_prod = !stat.prod_over;
                if (stat.prod_over || stat.inner_last)
                begin
                    cmd.next_i = !stat.i_last;
                end
                else
                begin
                    cmd.k_next = 1'b1;
                end
            end
            ST_DONE:  cmd.load_b   = stat.out_free;
            default:  cmd          = '0;
        endcase
    end

endmodule

// File: src/sps_dp.sv
// Datapath: factor table, prime list, multiplier, counters and result register.
module sps_dp import sps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  sps_cmd_t           cmd,
    output sps_stat_t          stat,
    input  logic               cfg_we,
    input  logic [FIELD_W-1:0] cfg_limit,
    input  logic [FIELD_W-1:0] req_query_value,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    output logic [1:0]         rsp_status,
    output logic [FIELD_W-1:0] rsp_smallest_factor,
    output logic               rsp_is_prime,
    output logic [COUNT_W-1:0] rsp_prime_count
);

    logic [ADDR_W-1:0] fmem [0:MAX_LIMIT];
    logic [ADDR_W-1:0] pmem [0:PRIME_DEPTH-1];

    // control state
    logic [FIELD_W-1:0]  limit_reg;
    logic [ADDR_W-1:0]   built_limit_reg;
    logic                built_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                rsp_valid_reg;

    // payload state
    logic [ADDR_W-1:0]   lim_reg;
    logic [ADDR_W-1:0]   i_reg;
    logic [ADDR_W-1:0]   clr_reg;
    logic [PIDX_W-1:0]   k_reg;
    logic [STORED_W-1:0] stored_reg;
    logic [ADDR_W-1:0]   f_reg;
    logic [ADDR_W-1:0]   p_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [FIELD_W-1:0]  qv_reg;
    logic [ADDR_W-1:0]   frd_reg;
    logic [ADDR_W-1:0]   prd_reg;
    logic [1:0]          status_reg;
    logic [FIELD_W-1:0]  factor_reg;
    logic                prime_reg;
    logic [COUNT_W-1:0]  pcount_reg;

    logic                fmem_we;
    logic [ADDR_W-1:0]   fmem_waddr;
    logic [ADDR_W-1:0]   fmem_wdata;
    logic                fmem_re;
    logic [ADDR_W-1:0]   fmem_raddr;
    logic                pmem_we;
    logic [ADDR_W-1:0]   lim_eff;
    logic                new_prime;
    logic                list_room;
    logic                q_over;
    status_t             q_status;

    assign new_prime = (frd_reg == '0);
    assign list_room = (stored_reg < STORED_W'(PRIME_DEPTH));
    assign q_over    = (WIDE_W'(qv_reg) > WIDE_W'(built_limit_reg));

    always_comb
    begin
        if (limit_reg < FIELD_W'(MIN_LIMIT))
        begin
            lim_eff = ADDR_W'(MIN_LIMIT);
        end
        else if (WIDE_W'(limit_reg) > WIDE_W'(MAX_LIMIT))
        begin
            lim_eff = ADDR_W'(MAX_LIMIT);
        end
        else
        begin
            lim_eff = ADDR_W'(limit_reg);
        end
    end

    // factor table port selection
    always_comb
    begin
        fmem_we    = 1'b0;
        fmem_waddr = clr_reg;
        fmem_wdata = '0;
        if (cmd.clr_step)
        begin
            fmem_we = 1'b1;
        end
        else if (cmd.chk_i && new_prime)
        begin
            fmem_we    = 1'b1;
            fmem_waddr = i_reg;
            fmem_wdata = i_reg;
        end
        else if (cmd.wr_prod)
        begin
            fmem_we    = 1'b1;
            fmem_waddr = prod_reg[ADDR_W-1:0];
            fmem_wdata = p_reg;
        end
        fmem_re    = cmd.q_read || cmd.rd_i;
        fmem_raddr = cmd.q_read ? ADDR_W'(req_query_value) : i_reg;
        pmem_we    = cmd.chk_i && new_prime && list_room;
    end

    always_ff @(posedge clk)
    begin
        if (fmem_we)
        begin
            fmem[fmem_waddr] <= fmem_wdata;
        end
        if (fmem_re)
        begin
            frd_reg <= fmem[fmem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pmem_we)
        begin
            pmem[stored_reg[PIDX_W-1:0]] <= i_reg;
        end
        if (cmd.rd_p)
        begin
            prd_reg <= pmem[k_reg];
        end
    end

    // sieve walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.q_read)
        begin
            qv_reg <= req_query_value;
        end
        if (cmd.build_start)
        begin
            lim_reg    <= lim_eff;
            clr_reg    <= '0;
            i_reg      <= ADDR_W'(MIN_LIMIT);
            stored_reg <= '0;
        end
        if (cmd.clr_step)
        begin
            clr_reg <= clr_reg + ADDR_W'(1);
        end
        if (cmd.chk_i)
        begin
            f_reg <= new_prime ? i_reg : frd_reg;
            k_reg <= '0;
            if (new_prime && list_room)
            begin
                stored_reg <= stored_reg + STORED_W'(1);
            end
        end
        if (cmd.mul)
        begin
            p_reg    <= prd_reg;
            prod_reg <= PROD_W'(prd_reg) * PROD_W'(i_reg);
        end
        if (cmd.k_next)
        begin
            k_reg <= k_reg + PIDX_W'(1);
        end
        if (cmd.next_i)
        begin
            i_reg <= i_reg + ADDR_W'(1);
        end
    end

    always_comb
    begin
        if (!built_reg)
        begin
            q_status = STATUS_UNBUILT;
        end
        else if (q_over)
        begin
            q_status = STATUS_RANGE;
        end
        else
        begin
            q_status = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg       <= FIELD_W'(65535);
            built_reg       <= 1'b0;
            built_limit_reg <= '0;
            count_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_limit;
            end
            if (cmd.build_start)
            begin
                count_reg <= '0;
            end
            else if (cmd.chk_i && new_prime && (count_reg != COUNT_W'(COUNT_MAX)))
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (cmd.load_b)
            begin
                built_reg       <= 1'b1;
                built_limit_reg <= lim_reg;
            end
            if (cmd.load_q || cmd.load_b)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_q)
        begin
            status_reg <= q_status;
            factor_reg <= (q_status == STATUS_OK) ? FIELD_W'(frd_reg) : '0;
            prime_reg  <= (q_status == STATUS_OK) && (qv_reg >= FIELD_W'(MIN_LIMIT))
                          && (frd_reg == ADDR_W'(qv_reg));
            pcount_reg <= built_reg ? count_reg : '0;
        end
        else if (cmd.load_b)
        begin
            status_reg <= STATUS_OK;
            factor_reg <= '0;
            prime_reg  <= 1'b0;
            pcount_reg <= count_reg;
        end
    end

    assign stat.clr_last   = (clr_reg == lim_reg);
    assign stat.prod_over  = (prod_reg > PROD_W'(lim_reg));
    assign stat.inner_last = (p_reg == f_reg)
                             || ((STORED_W'(k_reg) + STORED_W'(1)) == stored_reg);
    assign stat.i_last     = (i_reg == lim_reg);
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

    assign rsp_valid           = rsp_valid_reg;
    assign rsp_status          = status_reg;
    assign rsp_smallest_factor = factor_reg;
    assign rsp_is_prime        = prime_reg;
    assign rsp_prime_count     = pcount_reg;

endmodule

// File: src/sps_checker.sv
// Port-level assertions for the sieve unit and the bind that attaches them.
module sps_checker import sps_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [1:0]         rsp_status,
    input logic [FIELD_W-1:0] rsp_smallest_factor,
    input logic               rsp_is_prime,
    input logic [COUNT_W-1:0] rsp_prime_count
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before taken");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_smallest_factor)
                                    && $stable(rsp_is_prime) && $stable(rsp_prime_count))
        else $error("stalled response changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item taken while busy");

    a_unbuilt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == STATUS_UNBUILT) |->
            (rsp_prime_count == '0) && (rsp_smallest_factor == '0) && !rsp_is_prime)
        else $error("unbuilt response carries data");

    a_prime_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_prime |->
            (rsp_status == STATUS_OK) && (rsp_smallest_factor >= FIELD_W'(MIN_LIMIT)))
        else $error("prime flag on bad response");

endmodule

bind smallest_prime_factor_sieve_unit sps_checker u_sps_checker
(
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_smallest_factor (rsp.smallest_factor),
    .rsp_is_prime        (rsp.is_prime),
    .rsp_prime_count     (rsp.prime_count)
);

// File: tb/sv/tb_smallest_prime_factor_sieve_unit.sv
// Self-checking testbench for the smallest-prime-factor sieve unit.
module tb_smallest_prime_factor_sieve_unit;

    import sps_pkg::*;

    // Cycles with no handshake on any channel before the run is declared hung.
    // A full-range build runs with nothing accepted on any channel.
    localparam int WATCHDOG_LIMIT = 3000000;
    // Cycles the result side is held off once the flagged item goes in.
    localparam int LONG_HOLD      = 300;
    // Quiet cycles after the last result, so a stray extra result is caught.
    localparam int TAIL_CYCLES    = 64;
    localparam int RANDOM_ITEMS   = 750;

    // One entry of the stimulus queue: either a limit write or a request item.
    typedef struct packed {
        logic               is_cfg;
        opcode_t            op;
        logic [FIELD_W-1:0] value;   // query value, or the limit for a write
        logic               drain;   // hold back until every result is back
        logic               hold;    // kick off the long result-side hold-off
    } sieve_stim_t;

    typedef struct packed {
        status_t            status;
        logic [FIELD_W-1:0] factor;
        logic               prime;
        logic [COUNT_W-1:0] count;
    } sieve_answer_t;

    logic clk;
    logic rst_n;

    sps_cfg_if cfg_ch ();
    sps_req_if req_ch ();
    sps_rsp_if rsp_ch ();

    smallest_prime_factor_sieve_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    sieve_stim_t   stim_q [$];
    sieve_answer_t answer_q [$];

    int            outstanding;   // items accepted whose result is not back yet
    int            idle_cycles;   // watchdog: cycles since the last handshake
    int            mismatches;

    int unsigned   src_gap;
    int unsigned   src_run;
    int unsigned   sink_wait;
    int unsigned   sink_run;
    int unsigned   hold_left;
    logic          hold_kick;
    logic          cur_hold;

    // Predictor state: its own copy of the table, the prime list and the flags.
    int unsigned   spf_tab [0:MAX_LIMIT];
    int unsigned   plist [0:PRIME_DEPTH-1];
    int unsigned   model_limit;        // register as last written
    int unsigned   model_built_limit;  // effective limit latched by the last build
    int unsigned   model_count;
    logic          model_built;

    // Stimulus-side bookkeeping, only used to aim the query values.
    int unsigned   gen_cfg_limit;
    int unsigned   gen_built_limit;
    int unsigned   gen_items;

    // Gap before the next item: usually a uniform random draw, with runs of back-to-back items.
    function automatic int unsigned draw_gap(inout int unsigned run_left);
        if (run_left != 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic int unsigned clamp_limit(int unsigned lim);
        if (lim < MIN_LIMIT)
            return MIN_LIMIT;
        if (lim > MAX_LIMIT)
            return MAX_LIMIT;
        return lim;
    endfunction

    // Linear sieve over 2..limit: each composite is marked exactly once, by its
    // smallest prime. The prime count saturates; the list stops at its depth.
    function automatic void build_factor_table();
        int unsigned       lim;
        int unsigned       n;
        int unsigned       k;
        int unsigned       p;
        int unsigned       stored;
        longint unsigned   prod;
        lim = clamp_limit(model_limit);
        for (n = 0; n <= lim; n++)
            spf_tab[n] = 0;
        stored = 0;
        model_count = 0;
        for (n = 2; n <= lim; n++)
        begin
            if (spf_tab[n] == 0)
            begin
                spf_tab[n] = n;
                if (stored < PRIME_DEPTH)
                begin
                    plist[stored] = n;
                    stored++;
                end
                if (model_count < COUNT_MAX)
                    model_count++;
            end
            for (k = 0; k < stored; k++)
            begin
                p = plist[k];
                prod = longint'(p) * longint'(n);
                if (prod > lim)
                    break;
                spf_tab[prod] = p;
                if (spf_tab[n] == p)
                    break;
            end
        end
        model_built_limit = lim;
        model_built = 1'b1;
    endfunction

    task automatic add_item(opcode_t op, int unsigned value, logic drain, logic hold);
        sieve_stim_t s;
        s.is_cfg = 1'b0;
        s.op     = op;
        s.value  = value[FIELD_W-1:0];
        s.drain  = drain;
        s.hold   = hold;
        stim_q.push_back(s);
        gen_items++;
        if (op == OP_BUILD)
        begin
            gen_built_limit = clamp_limit(gen_cfg_limit);
        end
    endtask

    task automatic add_limit(int unsigned lim);
        sieve_stim_t s;
        s.is_cfg = 1'b1;
        s.op     = OP_BUILD;
        s.value  = lim[FIELD_W-1:0];
        s.drain  = 1'b1;
        s.hold   = 1'b0;
        stim_q.push_back(s);
        gen_cfg_limit = lim;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Driver: request and limit-write channels, fed from stim_q.
    // An entry that must drain (every limit write, and a few flagged items)
    // waits until no result is outstanding, so writes only land while idle.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : source_drv
        sieve_stim_t nxt;
        int          in_flight;
        logic        launch;
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.opcode      <= OP_BUILD;
            req_ch.query_value <= '0;
            cfg_ch.valid       <= 1'b0;
            cfg_ch.sieve_limit <= '0;
            src_gap            <= 0;
            src_run            <= 0;
            cur_hold           <= 1'b0;
            hold_kick          <= 1'b0;
        end
        else
        begin
            hold_kick <= req_ch.valid && req_ch.ready && cur_hold;
            // Results still owed after this edge, counting this edge's handshakes.
            in_flight = outstanding + int'(req_ch.valid && req_ch.ready)
                        - int'(rsp_ch.valid && rsp_ch.ready);
            if (!((req_ch.valid && !req_ch.ready) || (cfg_ch.valid && !cfg_ch.ready)))
            begin
                launch = 1'b0;
                if (src_gap != 0)
                    src_gap <= src_gap - 1;
                else if (stim_q.size() != 0)
                begin
                    nxt = stim_q[0];
                    if (!(nxt.is_cfg || nxt.drain) || in_flight == 0)
                    begin
                        launch = 1'b1;
                        void'(stim_q.pop_front());
                        src_gap <= draw_gap(src_run);
                    end
                end
                req_ch.valid <= launch && !nxt.is_cfg;
                cfg_ch.valid <= launch && nxt.is_cfg;
                if (launch && nxt.is_cfg)
                    cfg_ch.sieve_limit <= nxt.value;
                if (launch && !nxt.is_cfg)
                begin
                    req_ch.opcode      <= nxt.op;
                    req_ch.query_value <= nxt.value;
                    cur_hold           <= nxt.hold;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: long hold-off counter, then the per-item ready stall.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : long_hold
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= LONG_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin : sink_drv
        int unsigned wait_n;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            sink_wait    <= 0;
            sink_run     <= 0;
        end
        else
        begin
            wait_n = sink_wait;
            if (rsp_ch.valid && rsp_ch.ready)
                wait_n = draw_gap(sink_run);
            else if (wait_n != 0)
                wait_n--;
            sink_wait    <= wait_n;
            rsp_ch.ready <= (wait_n == 0) && (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result against the oldest expected answer,
    // tracks limit writes, and predicts the answer of each accepted item.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_mon
        sieve_answer_t      want;
        sieve_answer_t      got;
        logic [FIELD_W-1:0] v;
        if (!rst_n)
        begin
            outstanding       <= 0;
            idle_cycles       <= 0;
            answer_q.delete();
            model_limit       = MAX_LIMIT;
            model_built_limit = 0;
            model_count       = 0;
            model_built       = 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("result with nothing expected: status %0d factor %0d prime %0d count %0d",
                           rsp_ch.status, rsp_ch.smallest_factor, rsp_ch.is_prime,
                           rsp_ch.prime_count);
                    mismatches++;
                end
                else
                begin
                    got = answer_q.pop_front();
                    if (rsp_ch.status !== got.status)
                    begin
                        $error("status: expected %0d, got %0d", got.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.smallest_factor !== got.factor)
                    begin
                        $error("smallest_factor: expected %0d, got %0d",
                               got.factor, rsp_ch.smallest_factor);
                        mismatches++;
                    end
                    if (rsp_ch.is_prime !== got.prime)
                    begin
                        $error("is_prime: expected %0d, got %0d", got.prime, rsp_ch.is_prime);
                        mismatches++;
                    end
                    if (rsp_ch.prime_count !== got.count)
                    begin
                        $error("prime_count: expected %0d, got %0d",
                               got.count, rsp_ch.prime_count);
                        mismatches++;
                    end
                end
            end

            if (cfg_ch.valid && cfg_ch.ready)
                model_limit = 32'(cfg_ch.sieve_limit);

            if (req_ch.valid && req_ch.ready)
            begin
                want.status = STATUS_OK;
                want.factor = '0;
                want.prime  = 1'b0;
                want.count  = '0;
                v = req_ch.query_value;
                if (req_ch.opcode == OP_BUILD)
                begin
                    build_factor_table();
                    want.count = COUNT_W'(model_count);
                end
                else if (!model_built)
                    want.status = STATUS_UNBUILT;
                else
                begin
                    want.count = COUNT_W'(model_count);
                    // range is judged against the limit of the last build
                    if (v > model_built_limit)
                        want.status = STATUS_RANGE;
                    else
                    begin
                        want.factor = FIELD_W'(spf_tab[v]);
                        want.prime  = (v >= 2) && (spf_tab[v] == v);
                    end
                end
                answer_q.push_back(want);
            end

            outstanding <= outstanding + int'(req_ch.valid && req_ch.ready)
                           - int'(rsp_ch.valid && rsp_ch.ready);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned n_phase;
        int unsigned lim;
        int unsigned sel;
        int unsigned value;
        int unsigned k;
        int unsigned start_items;

        clk                = 1'b0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_BUILD;
        req_ch.query_value = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.sieve_limit = '0;
        rsp_ch.ready       = 1'b0;
        mismatches         = 0;
        gen_cfg_limit      = MAX_LIMIT;
        gen_built_limit    = 0;
        gen_items          = 0;

        // Directed part.
        // Queries before any build answer "not built".
        add_item(OP_QUERY, 0, 1'b0, 1'b0);
        add_item(OP_QUERY, MAX_LIMIT, 1'b0, 1'b0);
        // Limit 0 builds as limit 2; 3 then lies above it.
        add_limit(0);
        add_item(OP_BUILD, $urandom_range(0, MAX_LIMIT), 1'b0, 1'b0);
        add_item(OP_QUERY, 0, 1'b0, 1'b0);
        add_item(OP_QUERY, 1, 1'b0, 1'b0);
        add_item(OP_QUERY, 2, 1'b0, 1'b0);
        add_item(OP_QUERY, 3, 1'b0, 1'b0);
        add_limit(1);
        add_item(OP_BUILD, $urandom_range(0, MAX_LIMIT), 1'b0, 1'b0);
        add_item(OP_QUERY, 2, 1'b0, 1'b0);
        // New limit written but not built yet: range still follows the old build.
        add_limit(30);
        add_item(OP_QUERY, 20, 1'b0, 1'b0);
        add_item(OP_BUILD, $urandom_range(0, MAX_LIMIT), 1'b0, 1'b0);
        add_item(OP_QUERY, 29, 1'b0, 1'b0);
        add_item(OP_QUERY, 30, 1'b0, 1'b0);
        add_item(OP_QUERY, 25, 1'b0, 1'b0);
        add_item(OP_QUERY, 31, 1'b0, 1'b0);
        // Full-range build; the first query behind it starts the long hold-off
        // while the rest keep coming, and one item waits for a full drain.
        add_limit(MAX_LIMIT);
        add_item(OP_BUILD, $urandom_range(0, MAX_LIMIT), 1'b0, 1'b0);
        add_item(OP_QUERY, MAX_LIMIT, 1'b0, 1'b1);
        add_item(OP_QUERY, 65521, 1'b0, 1'b0);
        add_item(OP_QUERY, 65534, 1'b0, 1'b0);
        add_item(OP_QUERY, 32768, 1'b0, 1'b0);
        add_item(OP_QUERY, 4, 1'b1, 1'b0);
        add_item(OP_QUERY, 1, 1'b0, 1'b0);

        // Random part: phases of an optional limit write, an optional build, then a run of queries
        // with an occasional build. Limits stay small mostly, since a build's length grows with the limit.
        start_items = gen_items;
        while (gen_items - start_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 5) != 0)
            begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    lim = $urandom_range(0, 1);
                else if (sel == 1)
                    lim = $urandom_range(2, 3);
                else if (sel == 2)
                    lim = $urandom_range(401, 2000);
                else
                    lim = $urandom_range(4, 400);
                add_limit(lim);
            end
            // Now and then the new limit is queried against before it is built.
            if ($urandom_range(0, 7) != 0)
                add_item(OP_BUILD, $urandom, 1'b0, 1'b0);
            n_phase = $urandom_range(10, 45);
            for (k = 0; k < n_phase; k++)
            begin
                if ($urandom_range(0, 24) == 0)
                    add_item(OP_BUILD, $urandom, 1'b0, 1'b0);
                else
                begin
                    sel = $urandom_range(0, 9);
                    if (sel < 7)
                        value = $urandom_range(0, gen_built_limit);
                    else if (sel == 7)
                        value = (gen_built_limit + $urandom_range(0, 1)) & MAX_LIMIT;
                    else if (sel == 8 && gen_built_limit < MAX_LIMIT)
                        value = $urandom_range(gen_built_limit + 1, MAX_LIMIT);
                    else
                        value = $urandom_range(0, MAX_LIMIT);
                    add_item(OP_QUERY, value, ($urandom_range(0, 39) == 0), 1'b0);
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Sample at the falling edge, after all clocked updates have settled.
        @(negedge clk);
        while (!(stim_q.size() == 0 && !req_ch.valid && !cfg_ch.valid && outstanding == 0)
               && idle_cycles < WATCHDOG_LIMIT)
            @(negedge clk);

        if (idle_cycles >= WATCHDOG_LIMIT)
            $display("CHECK FAILED");
        else
        begin
            repeat (TAIL_CYCLES) @(negedge clk);
            if (mismatches == 0 && answer_q.size() == 0)
                $display("CHECK OK");
            else
                $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/sps_pkg.sv
src/sps_if.sv
src/sps_ctrl.sv
src/sps_dp.sv
src/smallest_prime_factor_sieve_unit.sv
src/sps_checker.sv
tb/sv/tb_smallest_prime_factor_sieve_unit.sv
